// ----- hw/rtl/cascaded_biquad_cabinet_filter_assert.svh -----
// Assertion macros used by the filter controller.
`ifndef CASCADED_BIQUAD_CABINET_FILTER_ASSERT_SVH
`define CASCADED_BIQUAD_CABINET_FILTER_ASSERT_SVH

// antecedent implies consequent in the same cycle
`define CBCF_ASSERT_NOW(lbl, ante, cons) \
  lbl: assert property (@(posedge clk_i) disable iff (!rst_ni) (ante) |-> (cons)) \
    else $error("cbcf assertion failed");

// antecedent implies consequent in the next cycle
`define CBCF_ASSERT_NEXT(lbl, ante, cons) \
  lbl: assert property (@(posedge clk_i) disable iff (!rst_ni) (ante) |=> (cons)) \
    else $error("cbcf assertion failed");

`endif

// ----- hw/rtl/cbcf_pkg.sv -----
// Package: types, constants and coefficient table of the biquad cabinet filter.
package cbcf_pkg;

  localparam int SampleBits = 24;
  localparam int SigBits    = 32;
  localparam int CoefBits   = 32;
  localparam int CoefFrac   = CoefBits - 3;
  localparam int TableRows  = 21;
  localparam int SecIdxW    = 5;
  localparam int RowBits    = 4 * SigBits;
  localparam longint DecScale = 64'sd10000000;
  localparam longint LevelDiv = 64'sd65025;
  localparam int QuotBits   = SampleBits;
  localparam int RemBits    = 40;
  // floor(2^47 / 65025) applied to the dividend without its low 8 bits
  localparam int RecipShift = 39;
  localparam longint LevelRecip = (64'sd1 <<< (RecipShift + 8)) / LevelDiv;

  localparam int CoefDec [TableRows][5] = '{
    '{ 2535983,  -4271075,  1798305, -19766557, 9773187},
    '{ 7331818, -13960759,  6803405, -19719342, 9977875},
    '{ 7067842, -13960759,  7037108, -13825947, 7233352},
    '{ 7293724, -13960759,  7013220, -19496058, 9735511},
    '{ 7202073, -13960759,  6776885, -19751961, 9790602},
    '{ 7689645, -13960759,  7318600, -18386308, 9271719},
    '{ 7045200, -13960759,  6953749, -15314613, 6271399},
    '{ 7086703, -13960759,  7057514, -19768190, 9841186},
    '{ 7445077, -13960759,  6898920, -18536366, 9560685},
    '{ 8977439, -13960759,  8315842, -19426912, 9884472},
    '{ 8086392, -13960759,  5874867, -17332788, 8955339},
    '{ 7444537, -13960759,  7275338, -19720077, 9922556},
    '{13960759,  -9765816,  3313676, -13537562, 7517743},
    '{ 7548130, -13960759,  6589689, -11740175, 1948560},
    '{13960759, -13915798, 10774110,  -1126680,  493799},
    '{ 8789463, -13960759,  7158386,  -1209507,   51930},
    '{13960759,  10942089,  2414824, -12878510, 6157815},
    '{13960759,   2645011,   954144,  -1585626,  137162},
    '{ 3621268,   3067125,  2203813, -18363155, 8997723},
    '{ 7376509,   4929292,   495974, -15067574, 8556021},
    '{ 4362469,   -280468,  3223825,   6816116, 1524044}
  };

  function automatic logic [TableRows*5*CoefBits-1:0] build_tab();
    logic [TableRows*5*CoefBits-1:0] v;
    longint d;
    longint m;
    longint q;
    longint c;
    v = '0;
    for (int r = 0; r < TableRows; r++) begin
      for (int k = 0; k < 5; k++) begin
        d = longint'(CoefDec[r][k]);
        m = (d < 0) ? -d : d;
        q = ((m <<< CoefFrac) + DecScale / 2) / DecScale;
        if (k < 3) begin
          c = (d < 0) ? -q : q;
        end else begin
          c = (d < 0) ? q : -q;
        end
        v[(r*5+k)*CoefBits +: CoefBits] = CoefBits'(c);
      end
    end
    return v;
  endfunction

  localparam logic [TableRows*5*CoefBits-1:0] CoefTab = build_tab();
  localparam logic signed [CoefBits-1:0] CoefOne = CoefBits'(64'sd1 <<< CoefFrac);

  function automatic logic signed [CoefBits-1:0] coef_f(input logic [SecIdxW-1:0] sec,
                                                       input logic [2:0] k);
    logic signed [CoefBits-1:0] c;
    if (int'(sec) < TableRows) begin
      c = CoefTab[(int'(sec)*5 + int'(k))*CoefBits +: CoefBits];
    end else begin
      c = (k == 3'd0) ? CoefOne : '0;
    end
    return c;
  endfunction

  typedef enum logic [3:0] {
    ST_IDLE, ST_RD, ST_MUL, ST_ACC, ST_WB, ST_LVL, ST_DST, ST_DIV, ST_OUT
  } cbcf_state_e;

  typedef struct packed {
    logic               load;
    logic               rd;
    logic [SecIdxW-1:0] sec;
    logic               mul;
    logic [2:0]         k;
    logic               acc_clr;
    logic               acc_add;
    logic               wb;
    logic               lvl;
    logic               div_start;
    logic               out_load;
  } cbcf_cmd_t;

  typedef struct packed {
    logic div_busy;
  } cbcf_status_t;

endpackage

// ----- hw/rtl/cbcf_if.sv -----
// Stream interfaces for the input and result words.
interface cbcf_in_if;
  logic                                  valid;
  logic                                  ready;
  logic signed [cbcf_pkg::SampleBits-1:0] sample_in;
  modport source (output valid, output sample_in, input ready);
  modport sink (input valid, input sample_in, output ready);
endinterface

interface cbcf_out_if;
  logic                                  valid;
  logic                                  ready;
  logic signed [cbcf_pkg::SampleBits-1:0] sample_out;
  modport source (output valid, output sample_out, input ready);
  modport sink (input valid, input sample_out, output ready);
endinterface

// ----- hw/rtl/cbcf_ram.sv -----
// Generic single-port-write, registered-read RAM.
module cbcf_ram #(
  parameter int Width = 128,
  parameter int Depth = 21
) (
  input  logic                                clk_i,
  input  logic                                we_i,
  input  logic [(Depth > 1 ? $clog2(Depth) : 1)-1:0] waddr_i,
  input  logic [Width-1:0]                    wdata_i,
  input  logic                                re_i,
  input  logic [(Depth > 1 ? $clog2(Depth) : 1)-1:0] raddr_i,
  output logic [Width-1:0]                    rdata_o
);
  logic [Width-1:0] mem_q [Depth];
  logic [Width-1:0] rdata_q;

  always_ff @(posedge clk_i) begin
    if (we_i) begin
      mem_q[waddr_i] <= wdata_i;
    end
    if (re_i) begin
      rdata_q <= mem_q[raddr_i];
    end
  end

  assign rdata_o = rdata_q;
endmodule

// ----- hw/rtl/cbcf_datapath.sv -----
// Datapath: history RAM, shared MAC, level multiply and reciprocal divide by 65025.
module cbcf_datapath #(
  parameter int SECTIONS = 21
) (
  input  logic                                   clk_i,
  input  logic                                   rst_ni,
  input  cbcf_pkg::cbcf_cmd_t                    cmd_i,
  output cbcf_pkg::cbcf_status_t                 status_o,
  input  logic signed [cbcf_pkg::SampleBits-1:0] sample_i,
  input  logic [7:0]                             level_knob_i,
  output logic signed [cbcf_pkg::SampleBits-1:0] sample_o
);
  localparam int SecW = (SECTIONS > 1) ? $clog2(SECTIONS) : 1;
  localparam int SB = cbcf_pkg::SigBits;
  localparam int RB = cbcf_pkg::RemBits;
  localparam int QB = cbcf_pkg::QuotBits;
  localparam int AccW = 67;
  localparam logic signed [AccW-1:0] RoundC = AccW'(64'sd1 <<< (cbcf_pkg::CoefFrac - 1));
  localparam logic [RB-1:0] DivC = RB'(cbcf_pkg::LevelDiv);
  localparam logic [RB-1:0] DivC2 = RB'(2 * cbcf_pkg::LevelDiv);
  localparam logic [31:0] RecipC = 32'(cbcf_pkg::LevelRecip);
  localparam logic [RB-1:0] RemMax =
    RB'((cbcf_pkg::LevelDiv <<< cbcf_pkg::QuotBits) - 64'sd1);
  localparam logic [QB-1:0] PosMax = {1'b0, {(QB-1){1'b1}}};
  localparam logic [QB-1:0] NegMin = {1'b1, {(QB-1){1'b0}}};

  logic signed [SB-1:0]   x_q;
  logic [SECTIONS-1:0]    valid_q;
  logic [cbcf_pkg::RowBits-1:0] rdata, row;
  logic signed [SB-1:0]   x1, x2, y1, y2, sig;
  logic signed [63:0]     prod_q;
  logic signed [AccW-1:0] acc_q;
  logic signed [AccW-cbcf_pkg::CoefFrac-1:0] tsh;
  logic signed [SB-1:0]   r;
  logic [20:0]            gain_q;
  logic signed [53:0]     num_q;
  logic [53:0]            mag;
  logic [RB-1:0]          rem_q, mrnd;
  logic [63:0]            rcp_q;
  logic [QB-1:0]          qest;
  logic [QB-1:0]          quot_q;
  logic [1:0]             cnt_q;
  logic                   busy_q;
  logic                   neg_q;
  logic signed [cbcf_pkg::SampleBits-1:0] out_q, out_d;
  logic [SecW-1:0]        addr;

  assign addr = cmd_i.sec[SecW-1:0];

  cbcf_ram #(.Width(cbcf_pkg::RowBits), .Depth(SECTIONS)) u_hist (
    .clk_i   (clk_i),
    .we_i    (cmd_i.wb),
    .waddr_i (addr),
    .wdata_i ({x_q, x1, r, y1}),
    .re_i    (cmd_i.rd),
    .raddr_i (addr),
    .rdata_o (rdata)
  );

  assign row = valid_q[addr] ? rdata : '0;
  assign x1 = row[4*SB-1:3*SB];
  assign x2 = row[3*SB-1:2*SB];
  assign y1 = row[2*SB-1:SB];
  assign y2 = row[SB-1:0];

  always_comb begin
    case (cmd_i.k)
      3'd0:    sig = x_q;
      3'd1:    sig = x1;
      3'd2:    sig = x2;
      3'd3:    sig = y1;
      3'd4:    sig = y2;
      default: sig = '0;
    endcase
  end

  assign tsh = acc_q[AccW-1:cbcf_pkg::CoefFrac];

  always_comb begin
    if (tsh > $signed({{(AccW-cbcf_pkg::CoefFrac-SB+1){1'b0}}, {(SB-1){1'b1}}})) begin
      r = {1'b0, {(SB-1){1'b1}}};
    end else if (tsh < $signed({{(AccW-cbcf_pkg::CoefFrac-SB+1){1'b1}}, {(SB-1){1'b0}}})) begin
      r = {1'b1, {(SB-1){1'b0}}};
    end else begin
      r = tsh[SB-1:0];
    end
  end

  assign mag  = num_q[53] ? 54'(-num_q) : 54'(num_q);
  assign mrnd = ((mag + 54'd32512) > 54'(RemMax)) ? RemMax
                                                  : RB'(mag + 54'd32512);
  // estimate never exceeds the true quotient and is at most two below it
  assign qest = rcp_q[cbcf_pkg::RecipShift +: QB];

  always_comb begin
    if (!neg_q) begin
      out_d = quot_q[QB-1] ? PosMax : quot_q;
    end else begin
      out_d = (quot_q > NegMin) ? NegMin : QB'(-quot_q);
    end
  end

  always_ff @(posedge clk_i or negedge rst_ni) begin
    if (!rst_ni) begin
      valid_q <= '0;
      busy_q  <= 1'b0;
      cnt_q   <= '0;
    end else begin
      if (cmd_i.wb) begin
        valid_q[addr] <= 1'b1;
      end
      if (cmd_i.div_start) begin
        busy_q <= 1'b1;
        cnt_q  <= 2'd2;
      end else if (busy_q) begin
        if (cnt_q == 2'd0) begin
          busy_q <= 1'b0;
        end else begin
          cnt_q <= cnt_q - 2'd1;
        end
      end
    end
  end

  always_ff @(posedge clk_i) begin
    gain_q <= 21'(16'(level_knob_i * level_knob_i) * 21'd20);
    if (cmd_i.load) begin
      x_q <= SB'(sample_i);
    end else if (cmd_i.wb) begin
      x_q <= r;
    end
    if (cmd_i.mul) begin
      prod_q <= 64'(sig) * 64'(cbcf_pkg::coef_f(cmd_i.sec, cmd_i.k));
    end
    if (cmd_i.acc_clr) begin
      acc_q <= RoundC;
    end else if (cmd_i.acc_add) begin
      acc_q <= acc_q + AccW'(prod_q);
    end
    if (cmd_i.lvl) begin
      num_q <= 54'(x_q) * $signed({33'd0, gain_q});
    end
    if (cmd_i.div_start) begin
      rem_q <= mrnd;
      neg_q <= num_q[53];
    end else if (busy_q) begin
      case (cnt_q)
        2'd2: begin
          rcp_q <= 64'(rem_q[RB-1:8]) * 64'(RecipC);
        end
        2'd1: begin
          quot_q <= qest;
          rem_q  <= rem_q - RB'(qest) * DivC;
        end
        2'd0: begin
          if (rem_q >= DivC2) begin
            quot_q <= quot_q + QB'(2);
          end else if (rem_q >= DivC) begin
            quot_q <= quot_q + QB'(1);
          end
        end
        default: begin
        end
      endcase
    end
    if (cmd_i.out_load) begin
      out_q <= out_d;
    end
  end

  assign status_o.div_busy = busy_q;
  assign sample_o = out_q;
endmodule

// ----- hw/rtl/cbcf_controller.sv -----
// Controller: sequences sections, MAC steps, level stage and handshakes.
`include "cascaded_biquad_cabinet_filter_assert.svh"
module cbcf_controller #(
  parameter int SECTIONS = 21
) (
  input  logic                   clk_i,
  input  logic                   rst_ni,
  input  logic                   in_valid_i,
  output logic                   in_ready_o,
  output logic                   out_valid_o,
  input  logic                   out_ready_i,
  input  cbcf_pkg::cbcf_status_t status_i,
  output cbcf_pkg::cbcf_cmd_t    cmd_o
);
  cbcf_pkg::cbcf_state_e state_q, state_d;
  logic [cbcf_pkg::SecIdxW-1:0] sec_q, sec_d;
  logic [2:0] k_q, k_d;
  logic out_valid_q, out_valid_d;

  always_ff @(posedge clk_i or negedge rst_ni) begin
    if (!rst_ni) begin
      state_q     <= cbcf_pkg::ST_IDLE;
      sec_q       <= '0;
      k_q         <= '0;
      out_valid_q <= 1'b0;
    end else begin
      state_q     <= state_d;
      sec_q       <= sec_d;
      k_q         <= k_d;
      out_valid_q <= out_valid_d;
    end
  end

  always_comb begin
    state_d = state_q;
    sec_d   = sec_q;
    k_d     = k_q;
    cmd_o   = '0;
    cmd_o.sec = sec_q;
    cmd_o.k   = k_q;
    in_ready_o = 1'b0;
    case (state_q)
      cbcf_pkg::ST_IDLE: begin
        in_ready_o = 1'b1;
        if (in_valid_i) begin
          cmd_o.load = 1'b1;
          sec_d   = '0;
          state_d = cbcf_pkg::ST_RD;
        end
      end
      cbcf_pkg::ST_RD: begin
        cmd_o.rd = 1'b1;
        k_d      = '0;
        state_d  = cbcf_pkg::ST_MUL;
      end
      cbcf_pkg::ST_MUL: begin
        cmd_o.mul     = 1'b1;
        cmd_o.acc_clr = (k_q == 3'd0);
        cmd_o.acc_add = (k_q != 3'd0);
        if (k_q == 3'd4) begin
          state_d = cbcf_pkg::ST_ACC;
        end else begin
          k_d = k_q + 3'd1;
        end
      end
      cbcf_pkg::ST_ACC: begin
        cmd_o.acc_add = 1'b1;
        state_d = cbcf_pkg::ST_WB;
      end
      cbcf_pkg::ST_WB: begin
        cmd_o.wb = 1'b1;
        if (sec_q == cbcf_pkg::SecIdxW'(SECTIONS - 1)) begin
          state_d = cbcf_pkg::ST_LVL;
        end else begin
          sec_d   = sec_q + 1'b1;
          state_d = cbcf_pkg::ST_RD;
        end
      end
      cbcf_pkg::ST_LVL: begin
        cmd_o.lvl = 1'b1;
        state_d = cbcf_pkg::ST_DST;
      end
      cbcf_pkg::ST_DST: begin
        cmd_o.div_start = 1'b1;
        state_d = cbcf_pkg::ST_DIV;
      end
      cbcf_pkg::ST_DIV: begin
        if (!status_i.div_busy) begin
          state_d = cbcf_pkg::ST_OUT;
        end
      end
      cbcf_pkg::ST_OUT: begin
        if (!out_valid_q || out_ready_i) begin
          cmd_o.out_load = 1'b1;
          state_d = cbcf_pkg::ST_IDLE;
        end
      end
      default: begin
        state_d = cbcf_pkg::ST_IDLE;
      end
    endcase
  end

  always_comb begin
    if (cmd_o.out_load) begin
      out_valid_d = 1'b1;
    end else if (out_ready_i) begin
      out_valid_d = 1'b0;
    end else begin
      out_valid_d = out_valid_q;
    end
  end

  assign out_valid_o = out_valid_q;

  `CBCF_ASSERT_NOW(a_out_free, cmd_o.out_load, !out_valid_q || out_ready_i)
  `CBCF_ASSERT_NEXT(a_start, state_q == cbcf_pkg::ST_IDLE && in_valid_i,
                    state_q == cbcf_pkg::ST_RD && sec_q == '0)
  `CBCF_ASSERT_NOW(a_k_range, state_q == cbcf_pkg::ST_MUL, k_q <= 3'd4)
  `CBCF_ASSERT_NOW(a_sec_range, state_q != cbcf_pkg::ST_IDLE,
                   sec_q <= cbcf_pkg::SecIdxW'(SECTIONS - 1))
endmodule

// ----- hw/rtl/cascaded_biquad_cabinet_filter.sv -----
// Cascaded biquad cabinet filter: a chain of SECTIONS direct form I biquads
// with fixed coefficients and an output level stage. Each section in turn
// reads its history RAM row, runs its five coefficient products through the
// shared multiplier, finishes the sum and writes back; the level stage then
// does the gain multiply, a reciprocal multiply by 1/65025 with a remainder
// correction, and the output load. A new sample is taken once the previous
// one has left the chain, while its result may still wait in the output
// register; a result that still waits holds the next one before the load.
module cascaded_biquad_cabinet_filter #(
  parameter int SECTIONS = 21
) (
  input  logic        clk_i,
  input  logic        rst_ni,
  cbcf_in_if.sink     in_i,
  cbcf_out_if.source  out_o,
  input  logic        psel,
  input  logic        penable,
  input  logic        pwrite,
  input  logic [2:0]  paddr,
  input  logic [31:0] pwdata,
  output logic [31:0] prdata,
  output logic        pready
);
  logic [7:0] level_knob_q;
  cbcf_pkg::cbcf_cmd_t    cmd;
  cbcf_pkg::cbcf_status_t status;

  assign pready = 1'b1;

  always_ff @(posedge clk_i or negedge rst_ni) begin
    if (!rst_ni) begin
      level_knob_q <= 8'd255;
    end else if (psel && penable && pwrite && !paddr[2]) begin
      level_knob_q <= pwdata[7:0];
    end
  end

  assign prdata = paddr[2] ? 32'd0 : {24'd0, level_knob_q};

  cbcf_controller #(.SECTIONS(SECTIONS)) u_ctrl (
    .clk_i       (clk_i),
    .rst_ni      (rst_ni),
    .in_valid_i  (in_i.valid),
    .in_ready_o  (in_i.ready),
    .out_valid_o (out_o.valid),
    .out_ready_i (out_o.ready),
    .status_i    (status),
    .cmd_o       (cmd)
  );

  cbcf_datapath #(.SECTIONS(SECTIONS)) u_dp (
    .clk_i        (clk_i),
    .rst_ni       (rst_ni),
    .cmd_i        (cmd),
    .status_o     (status),
    .sample_i     (in_i.sample_in),
    .level_knob_i (level_knob_q),
    .sample_o     (out_o.sample_out)
  );
endmodule
